// ===== design/fud_pkg.sv =====
// ----------------------------------------------------------------------------
// fud_pkg
// Shared types and constants of the form-urlencoded decoder: parser modes,
// result kinds and the entry that travels from the parser to the output side.
// ----------------------------------------------------------------------------
`default_nettype none

package fud_pkg;

  // Special characters of the encoding.
  localparam logic [7:0] CHAR_AMP     = 8'h26;
  localparam logic [7:0] CHAR_EQUALS  = 8'h3d;
  localparam logic [7:0] CHAR_PLUS    = 8'h2b;
  localparam logic [7:0] CHAR_PERCENT = 8'h25;
  localparam logic [7:0] CHAR_SPACE   = 8'h20;

  // Result kinds as they appear on the output channel.
  localparam logic [2:0] KIND_NAME   = 3'd0;
  localparam logic [2:0] KIND_VALUE  = 3'd1;
  localparam logic [2:0] KIND_COMMIT = 3'd2;
  localparam logic [2:0] KIND_DROP   = 3'd3;
  localparam logic [2:0] KIND_END    = 3'd4;

  // Parser modes.
  typedef enum logic [2:0] {
    MODE_START  = 3'd0,
    MODE_SKIP   = 3'd1,
    MODE_NAME   = 3'd2,
    MODE_VALUE  = 3'd3,
    MODE_ESC_HI = 3'd4,
    MODE_ESC_LO = 3'd5
  } mode_t;

  // One result item.
  typedef struct packed {
    logic [2:0] kind;
    logic [7:0] decoded_byte;
    logic       end_of_body;
  } result_t;

  // All results caused by one input item: one or two.
  typedef struct packed {
    result_t first;
    result_t second;
    logic    has_second;
  } entry_t;

endpackage

`default_nettype wire

// ===== design/fud_if.sv =====
// ----------------------------------------------------------------------------
// fud_in_if / fud_out_if
// Valid/ready channels of the decoder: encoded bytes in, decoded results out.
// ----------------------------------------------------------------------------
`default_nettype none

interface fud_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] text_byte;
  logic       is_final;

  modport source (output valid, output text_byte, output is_final, input ready);
  modport sink   (input valid, input text_byte, input is_final, output ready);
endinterface

interface fud_out_if;
  logic       valid;
  logic       ready;
  logic [2:0] kind;
  logic [7:0] decoded_byte;
  logic       end_of_body;

  modport source (output valid, output kind, output decoded_byte, output end_of_body,
                  input ready);
  modport sink   (input valid, input kind, input decoded_byte, input end_of_body,
                  output ready);
endinterface

`default_nettype wire

// ===== design/form_urlencoded_decoder_top.sv =====
// ----------------------------------------------------------------------------
// form_urlencoded_decoder_top
// Streaming decoder for form-urlencoded bodies, one encoded byte per item.
// ----------------------------------------------------------------------------
// Usage:
//   The text channel carries one raw body byte per item, with is_final set
//   on the last byte of a body. The result channel carries decoded name and
//   value bytes and pair events (committed, dropped, end only); end_of_body
//   marks the last result caused by a final byte.
//   Each input byte yields zero, one or two results. A byte is taken every
//   cycle while the entry queue has room; a result passes from the parser
//   through the queue and the output register on its way out.
//   The output side sends one result per cycle while the receiver is ready,
//   so a byte that causes two results holds it for both in turn; the queue
//   of QUEUE_DEPTH entries absorbs such bytes and short output stalls.
//   When the receiver stalls, the output register holds its item and the
//   queue fills; once it is full, text.ready drops until space frees up.
//   Reset clears the parse state, empties the queue and the output stage.
// ----------------------------------------------------------------------------
`default_nettype none

module form_urlencoded_decoder_top #(
  parameter int QUEUE_DEPTH = 4
) (
  input  wire logic clk,
  input  wire logic rst,
  fud_in_if.sink    text,
  fud_out_if.source result
);
  import fud_pkg::*;

  logic   push_valid;
  entry_t push_entry;
  logic   push_ready;
  logic   pop_valid;
  entry_t pop_entry;
  logic   pop_ready;

  fud_front u_front (
    .clk        (clk),
    .rst        (rst),
    .text       (text),
    .push_valid (push_valid),
    .push_entry (push_entry),
    .push_ready (push_ready)
  );

  fud_fifo #(
    .DEPTH (QUEUE_DEPTH)
  ) u_fifo (
    .clk        (clk),
    .rst        (rst),
    .push_valid (push_valid),
    .push_entry (push_entry),
    .push_ready (push_ready),
    .pop_valid  (pop_valid),
    .pop_entry  (pop_entry),
    .pop_ready  (pop_ready)
  );

  fud_back u_back (
    .clk       (clk),
    .rst       (rst),
    .pop_valid (pop_valid),
    .pop_entry (pop_entry),
    .pop_ready (pop_ready),
    .result    (result)
  );

endmodule

`default_nettype wire

// ===== design/fud_front.sv =====
// ----------------------------------------------------------------------------
// fud_front
// Parser: takes one encoded byte per cycle while the queue has room,
// advances the parse state and packs any results of the byte into an entry.
// ----------------------------------------------------------------------------
`default_nettype none

module fud_front (
  input  wire logic           clk,
  input  wire logic           rst,
  fud_in_if.sink              text,
  output logic                push_valid,
  output fud_pkg::entry_t     push_entry,
  input  wire logic           push_ready
);
  import fud_pkg::*;

  // Hex digit value; anything that is not a hex digit counts as zero.
  function automatic logic [3:0] hex_value(input logic [7:0] c);
    logic [3:0] v;
    v = 4'd0;
    if (c >= 8'h30 && c <= 8'h39) v = 4'(c - 8'h30);
    else if (c >= 8'h61 && c <= 8'h66) v = 4'(c - 8'h57);
    else if (c >= 8'h41 && c <= 8'h46) v = 4'(c - 8'h37);
    return v;
  endfunction

  mode_t      mode, mode_next;
  logic       resume_in_value, resume_in_value_next;
  logic [3:0] high_nibble, high_nibble_next;

  logic       accept;
  logic       has_data;
  logic [2:0] data_kind;
  logic [7:0] data_byte;
  logic       has_commit;
  logic       has_main;
  logic       has_tail;
  logic [2:0] tail_kind;
  logic [7:0] b;

  assign b          = text.text_byte;
  assign text.ready = push_ready;
  assign accept     = text.valid & push_ready;

  // Parse state register; the final byte of a body returns it to reset.
  always_ff @(posedge clk) begin
    if (rst) begin
      mode            <= MODE_START;
      resume_in_value <= 1'b0;
      high_nibble     <= 4'd0;
    end else if (accept) begin
      if (text.is_final) begin
        mode            <= MODE_START;
        resume_in_value <= 1'b0;
        high_nibble     <= 4'd0;
      end else begin
        mode            <= mode_next;
        resume_in_value <= resume_in_value_next;
        high_nibble     <= high_nibble_next;
      end
    end
  end

  // Next state and the byte-level result.
  always_comb begin
    mode_next            = mode;
    resume_in_value_next = resume_in_value;
    high_nibble_next     = high_nibble;
    has_data             = 1'b0;
    data_kind            = KIND_NAME;
    data_byte            = b;
    has_commit           = 1'b0;

    unique case (mode)
      MODE_SKIP: begin
        if (b == CHAR_AMP) mode_next = MODE_START;
      end
      MODE_NAME, MODE_VALUE: begin
        if (mode == MODE_NAME && b == CHAR_EQUALS) begin
          mode_next = MODE_VALUE;
        end else if (mode == MODE_VALUE && b == CHAR_AMP) begin
          has_commit = 1'b1;
          mode_next  = MODE_START;
        end else if (b == CHAR_PERCENT) begin
          resume_in_value_next = (mode == MODE_VALUE);
          mode_next            = MODE_ESC_HI;
        end else begin
          has_data  = 1'b1;
          data_kind = (mode == MODE_VALUE) ? KIND_VALUE : KIND_NAME;
          data_byte = (b == CHAR_PLUS) ? CHAR_SPACE : b;
        end
      end
      MODE_ESC_HI: begin
        high_nibble_next = hex_value(b);
        mode_next        = MODE_ESC_LO;
      end
      MODE_ESC_LO: begin
        has_data  = 1'b1;
        data_kind = resume_in_value ? KIND_VALUE : KIND_NAME;
        data_byte = {high_nibble, hex_value(b)};
        mode_next = resume_in_value ? MODE_VALUE : MODE_NAME;
      end
      default: begin
        // Start of pair, and any unused mode code.
        if (b == CHAR_AMP) begin
          mode_next = MODE_START;
        end else if (b == CHAR_EQUALS) begin
          mode_next = MODE_SKIP;
        end else if (b == CHAR_PERCENT) begin
          resume_in_value_next = 1'b0;
          mode_next            = MODE_ESC_HI;
        end else begin
          mode_next = MODE_NAME;
          has_data  = 1'b1;
          data_kind = KIND_NAME;
          data_byte = (b == CHAR_PLUS) ? CHAR_SPACE : b;
        end
      end
    endcase
  end

  assign has_main = has_data | has_commit;

  // End-of-body result, chosen by the mode the byte leaves behind.
  always_comb begin
    has_tail  = 1'b0;
    tail_kind = KIND_END;
    if (text.is_final) begin
      unique case (mode_next)
        MODE_NAME, MODE_ESC_HI, MODE_ESC_LO: begin
          has_tail  = 1'b1;
          tail_kind = KIND_DROP;
        end
        MODE_VALUE: begin
          has_tail  = 1'b1;
          tail_kind = KIND_COMMIT;
        end
        default: begin
          has_tail  = !has_main;
          tail_kind = KIND_END;
        end
      endcase
    end
  end

  // Pack the results; the end-of-body mark goes on the last one.
  always_comb begin
    push_entry = '0;
    if (has_main) begin
      push_entry.first.kind         = has_commit ? KIND_COMMIT : data_kind;
      push_entry.first.decoded_byte = has_commit ? 8'd0 : data_byte;
      push_entry.first.end_of_body  = text.is_final & !has_tail;
      push_entry.has_second         = has_tail;
      push_entry.second.kind        = tail_kind;
      push_entry.second.end_of_body = 1'b1;
    end else begin
      push_entry.first.kind         = tail_kind;
      push_entry.first.end_of_body  = 1'b1;
    end
  end

  assign push_valid = accept & (has_main | has_tail);

endmodule

`default_nettype wire

// ===== design/fud_fifo.sv =====
// ----------------------------------------------------------------------------
// fud_fifo
// Short queue of result entries between the parser and the output side.
// ----------------------------------------------------------------------------
`default_nettype none

module fud_fifo #(
  parameter int DEPTH = 4
) (
  input  wire logic           clk,
  input  wire logic           rst,
  input  wire logic           push_valid,
  input  fud_pkg::entry_t     push_entry,
  output logic                push_ready,
  output logic                pop_valid,
  output fud_pkg::entry_t     pop_entry,
  input  wire logic           pop_ready
);
  import fud_pkg::*;

  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW = $clog2(DEPTH + 1);
  localparam logic [AW-1:0] LAST = AW'(DEPTH - 1);

  entry_t        store [DEPTH];
  logic [AW-1:0] wr_ptr;
  logic [AW-1:0] rd_ptr;
  logic [CW-1:0] count;
  logic          do_push;
  logic          do_pop;

  assign push_ready = (count != CW'(DEPTH));
  assign pop_valid  = (count != '0);
  assign pop_entry  = store[rd_ptr];
  assign do_push    = push_valid & push_ready;
  assign do_pop     = pop_valid & pop_ready;

  // Entry storage.
  always_ff @(posedge clk) begin
    if (do_push) store[wr_ptr] <= push_entry;
  end

  // Pointers and fill count.
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (do_push) wr_ptr <= (wr_ptr == LAST) ? '0 : wr_ptr + 1'b1;
      if (do_pop)  rd_ptr <= (rd_ptr == LAST) ? '0 : rd_ptr + 1'b1;
      if (do_push && !do_pop)      count <= count + 1'b1;
      else if (do_pop && !do_push) count <= count - 1'b1;
    end
  end

endmodule

`default_nettype wire

// ===== design/fud_back.sv =====
// ----------------------------------------------------------------------------
// fud_back
// Output side: takes queue entries and sends their results one per cycle,
// while the receiver is ready, through a registered output stage.
// ----------------------------------------------------------------------------
`default_nettype none

module fud_back (
  input  wire logic           clk,
  input  wire logic           rst,
  input  wire logic           pop_valid,
  input  fud_pkg::entry_t     pop_entry,
  output logic                pop_ready,
  fud_out_if.source           result
);
  import fud_pkg::*;

  logic    out_valid;
  result_t out_item;
  logic    pend_valid;
  result_t pend_item;
  logic    load;

  // The output register can take a new item when empty or being drained.
  assign load      = !out_valid | result.ready;
  assign pop_ready = load & !pend_valid;

  // Control flags.
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid  <= 1'b0;
      pend_valid <= 1'b0;
    end else if (load) begin
      if (pend_valid) begin
        out_valid  <= 1'b1;
        pend_valid <= 1'b0;
      end else begin
        out_valid  <= pop_valid;
        pend_valid <= pop_valid & pop_entry.has_second;
      end
    end
  end

  // Payload registers.
  always_ff @(posedge clk) begin
    if (load) begin
      if (pend_valid) begin
        out_item <= pend_item;
      end else if (pop_valid) begin
        out_item  <= pop_entry.first;
        pend_item <= pop_entry.second;
      end
    end
  end

  assign result.valid        = out_valid;
  assign result.kind         = out_item.kind;
  assign result.decoded_byte = out_item.decoded_byte;
  assign result.end_of_body  = out_item.end_of_body;

endmodule

`default_nettype wire
